FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the rest detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BRD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/brd_pkg.sv
// Package with the widths, register codes, record type and smoothing function of the rest detector.
package brd_pkg;

    localparam int ID_W       = 6;
    localparam int SPEED_W    = 16;
    localparam int DWELL_W    = 24;
    localparam int WAKE_W     = 8;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};

    // Exponential average weights: 205/256 on the old value, 51/256 on the new sample.
    localparam logic [7:0] EMA_OLD_GAIN = 8'd205;
    localparam logic [7:0] EMA_NEW_GAIN = 8'd51;
    localparam logic [7:0] EMA_ROUND    = 8'd128;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_THR    = 3'd0,
        CFG_ANG_THR    = 3'd1,
        CFG_WAKE_SCALE = 3'd2,
        CFG_TIME_STEP  = 3'd3,
        CFG_SLEEP_DLY  = 3'd4
    } cfg_reg_t;

    // One stored body record.
    typedef struct packed {
        logic               cand;
        logic [SPEED_W-1:0] lin;
        logic [SPEED_W-1:0] ang;
        logic [DWELL_W-1:0] dwell;
    } body_rec_t;

    localparam int REC_W = $bits(body_rec_t);

    // Fixed-point smoothing step: (205*old + 51*now + 128) >> 8.
    function automatic logic [SPEED_W-1:0] ema(input logic [SPEED_W-1:0] old_val,
                                               input logic [SPEED_W-1:0] now_val);
        logic [SPEED_W+7:0] acc;
        acc = (SPEED_W+8)'(old_val) * (SPEED_W+8)'(EMA_OLD_GAIN)
            + (SPEED_W+8)'(now_val) * (SPEED_W+8)'(EMA_NEW_GAIN)
            + (SPEED_W+8)'(EMA_ROUND);
        return acc[SPEED_W+7:8];
    endfunction

endpackage

FILE: rtl/brd_if.sv
// Valid/ready channel interfaces for the rest detector input and result streams.
interface brd_in_if;
    import brd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    body_index;
    logic [SPEED_W-1:0] lin_speed_now;
    logic [SPEED_W-1:0] ang_speed_now;
    logic               disturbed;
    logic               in_island;

    modport source (output valid, body_index, lin_speed_now, ang_speed_now, disturbed,
                    in_island, input ready);
    modport sink   (input valid, body_index, lin_speed_now, ang_speed_now, disturbed,
                    in_island, output ready);
endinterface

interface brd_out_if;
    import brd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    body_id;
    logic               sleep_candidate;
    logic [SPEED_W-1:0] lin_speed_smooth;
    logic [SPEED_W-1:0] ang_speed_smooth;
    logic [DWELL_W-1:0] dwell_us;

    modport source (output valid, body_id, sleep_candidate, lin_speed_smooth,
                    ang_speed_smooth, dwell_us, input ready);
    modport sink   (input valid, body_id, sleep_candidate, lin_speed_smooth,
                    ang_speed_smooth, dwell_us, output ready);
endinterface

FILE: rtl/brd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module brd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of the entry being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/body_rest_detector_unit.sv
// Top level of the per-body rest detector: configuration, body-state RAM and update pipeline.
//
// Usage: items arrive on in_ch (valid/ready); a transfer takes place at a rising clk edge
// with valid and ready both high. Each item names a body and carries its instantaneous
// linear and angular speeds plus the disturbed and in-island flags. For every input
// transfer exactly one result leaves on out_ch, in input order.
// The result is registered through the read stage, decision stage and output register.
// A new item is not taken while the previous one is in the read stage. The body state
// lives in a RAM with a registered read port; an item reads its record in the cycle of
// its transfer and writes it back when it leaves the decision stage, and the next item's
// read can be issued in that write-back cycle, with the written record forwarded to it.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only while idle.
// Reset: rst_n low clears all control state, loads the register defaults and marks every
// body record invalid, so each body reads as all zeros until first written. No clearing
// pass is needed; the block can take items as soon as reset is released.
// Stall: when out_ch.ready is low the result holds in the output register; one more item
// is accepted and waits in the decision stage behind it, then in_ch.ready stays low until
// the result leaves.
module body_rest_detector_unit #(
    parameter int MAX_BODIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0] cfg_data,
    brd_in_if.sink                         in_ch,
    brd_out_if.source                      out_ch
);
    import brd_pkg::*;

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

    // Configuration registers.
    logic [SPEED_W-1:0] lin_thr_reg;
    logic [SPEED_W-1:0] ang_thr_reg;
    logic [WAKE_W-1:0]  wake_scale_reg;
    logic [STEP_W-1:0]  time_step_reg;
    logic [DWELL_W-1:0] sleep_dly_reg;

    // Pipeline control.
    logic b_valid_reg;
    logic c_valid_reg;
    logic out_valid_reg;
    logic fwd_valid_reg;
    logic [MAX_BODIES-1:0] rec_valid_reg;

    // Read stage payload.
    logic [ID_W-1:0]    b_id_reg;
    logic [AW-1:0]      b_addr_reg;
    logic               b_in_range_reg;
    logic [SPEED_W-1:0] b_lin_now_reg;
    logic [SPEED_W-1:0] b_ang_now_reg;
    logic               b_dist_reg;
    logic               b_island_reg;

    // Decision stage payload.
    logic [ID_W-1:0]    c_id_reg;
    logic [AW-1:0]      c_addr_reg;
    logic               c_in_range_reg;
    logic               c_dist_reg;
    logic               c_island_reg;
    body_rec_t          c_rec_reg;

    // Forwarding of the last record written.
    logic [AW-1:0]      fwd_addr_reg;
    body_rec_t          fwd_rec_reg;

    // Output register.
    logic [ID_W-1:0]    out_id_reg;
    body_rec_t          out_rec_reg;

    logic               in_xfer;
    logic               out_free;
    logic               c_fire;
    logic               ram_we;
    logic [AW-1:0]      in_addr;
    logic               in_in_range;
    logic [REC_W-1:0]   ram_rdata;
    body_rec_t          rec_old;
    body_rec_t          b_rec;
    body_rec_t          c_rec_next;
    logic               lin_wake;
    logic               ang_wake;
    logic               quiet;
    logic [DWELL_W:0]   dwell_sum;
    logic [DWELL_W-1:0] dwell_sat;

    // Handshake and stage movement.
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign c_fire      = c_valid_reg && out_free;
    assign in_ch.ready = !b_valid_reg && (!c_valid_reg || c_fire);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign in_addr     = AW'(in_ch.body_index);
    assign in_in_range = (32'(in_ch.body_index) < MAX_BODIES);
    assign ram_we      = c_fire && c_in_range_reg;

    brd_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_BODIES),
        .AW    (AW)
    ) u_brd_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_addr_reg),
        .wdata (c_rec_next),
        .re    (in_xfer),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Read stage: pick forwarded, stored or reset record, then smooth the speeds of an in-island item.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == b_addr_reg))
        begin
            rec_old = fwd_rec_reg;
        end
        else if (rec_valid_reg[b_addr_reg])
        begin
            rec_old = body_rec_t'(ram_rdata);
        end
        else
        begin
            rec_old = '0;
        end
        b_rec = rec_old;
        if (b_island_reg)
        begin
            b_rec.lin = ema(rec_old.lin, b_lin_now_reg);
            b_rec.ang = ema(rec_old.ang, b_ang_now_reg);
        end
    end

    // Decision stage: wake and quiet tests, dwell accumulation and candidacy.
    always_comb
    begin
        lin_wake   = (24'(c_rec_reg.lin) << 4) > (24'(wake_scale_reg) * 24'(lin_thr_reg));
        ang_wake   = (24'(c_rec_reg.ang) << 4) > (24'(wake_scale_reg) * 24'(ang_thr_reg));
        quiet      = (c_rec_reg.lin < lin_thr_reg) && (c_rec_reg.ang < ang_thr_reg)
                     && !c_dist_reg;
        dwell_sum  = (DWELL_W+1)'(c_rec_reg.dwell) + (DWELL_W+1)'(time_step_reg);
        dwell_sat  = dwell_sum[DWELL_W] ? DWELL_MAX : dwell_sum[DWELL_W-1:0];
        c_rec_next = c_rec_reg;
        if (!c_island_reg)
        begin
            c_rec_next.cand = 1'b0;
        end
        else if (c_rec_reg.cand)
        begin
            if (c_dist_reg || lin_wake || ang_wake)
            begin
                c_rec_next.cand = 1'b0;
            end
        end
        else if (quiet)
        begin
            c_rec_next.dwell = dwell_sat;
            if (dwell_sat >= sleep_dly_reg)
            begin
                c_rec_next.cand = 1'b1;
            end
        end
        else
        begin
            c_rec_next.dwell = '0;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_thr_reg    <= SPEED_W'(26);
            ang_thr_reg    <= SPEED_W'(26);
            wake_scale_reg <= WAKE_W'(32);
            time_step_reg  <= STEP_W'(1000);
            sleep_dly_reg  <= DWELL_W'(500000);
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            rec_valid_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_LIN_THR:    lin_thr_reg    <= cfg_data[SPEED_W-1:0];
                    CFG_ANG_THR:    ang_thr_reg    <= cfg_data[SPEED_W-1:0];
                    CFG_WAKE_SCALE: wake_scale_reg <= cfg_data[WAKE_W-1:0];
                    CFG_TIME_STEP:  time_step_reg  <= cfg_data[STEP_W-1:0];
                    CFG_SLEEP_DLY:  sleep_dly_reg  <= cfg_data[DWELL_W-1:0];
                    default:        ;
                endcase
            end
            b_valid_reg <= in_xfer;
            if (b_valid_reg)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_fire)
            begin
                c_valid_reg <= 1'b0;
            end
            if (c_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                fwd_valid_reg             <= 1'b1;
                rec_valid_reg[c_addr_reg] <= 1'b1;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            b_id_reg       <= in_ch.body_index;
            b_addr_reg     <= in_addr;
            b_in_range_reg <= in_in_range;
            b_lin_now_reg  <= in_ch.lin_speed_now;
            b_ang_now_reg  <= in_ch.ang_speed_now;
            b_dist_reg     <= in_ch.disturbed;
            b_island_reg   <= in_ch.in_island;
        end
        if (b_valid_reg)
        begin
            c_id_reg       <= b_id_reg;
            c_addr_reg     <= b_addr_reg;
            c_in_range_reg <= b_in_range_reg;
            c_dist_reg     <= b_dist_reg;
            c_island_reg   <= b_island_reg;
            c_rec_reg      <= b_rec;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= c_addr_reg;
            fwd_rec_reg  <= c_rec_next;
        end
        if (c_fire)
        begin
            out_id_reg  <= c_id_reg;
            out_rec_reg <= c_in_range_reg ? c_rec_next : '0;
        end
    end

    // Result channel.
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.body_id          = out_id_reg;
    assign out_ch.sleep_candidate  = out_rec_reg.cand;
    assign out_ch.lin_speed_smooth = out_rec_reg.lin;
    assign out_ch.ang_speed_smooth = out_rec_reg.ang;
    assign out_ch.dwell_us         = out_rec_reg.dwell;

endmodule

FILE: rtl/brd_checker.sv
// Port-level checker for the rest detector, bound to the top level.
`include "assert_macros.svh"

module brd_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [brd_pkg::ID_W+2*brd_pkg::SPEED_W+brd_pkg::DWELL_W:0] out_data
);
    import brd_pkg::*;

    logic in_xfer;
    logic in_xfer_d1_reg;
    logic in_xfer_d2_reg;

    assign in_xfer = in_valid && in_ready;

    // Delay line of input transfers for the latency check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_xfer_d1_reg <= 1'b0;
            in_xfer_d2_reg <= 1'b0;
        end
        else
        begin
            in_xfer_d1_reg <= in_xfer;
            in_xfer_d2_reg <= in_xfer_d1_reg;
        end
    end

    // A stalled result stays valid and unchanged.
    `BRD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // The read-modify-write round trip leaves a gap after every input transfer.
    `BRD_ASSERT_NXT(a_in_gap, in_xfer, !in_ready, "input accepted on back-to-back cycles")

    // A result entering an empty output register passed the read and decision stages without waiting.
    `BRD_ASSERT_IMP(a_out_latency, $rose(out_valid), $past(in_xfer_d2_reg), "result without matching input transfer")

endmodule

bind body_rest_detector_unit brd_checker u_brd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  ({out_ch.body_id, out_ch.sleep_candidate, out_ch.lin_speed_smooth,
                 out_ch.ang_speed_smooth, out_ch.dwell_us})
);

FILE: sim/tb_body_rest_detector_unit.sv
// Self-checking testbench for the per-body rest detector: queued stimulus, handshake driver, result monitor.
`timescale 1ns / 1ps

module tb_body_rest_detector_unit;
    import brd_pkg::*;

    localparam int    N_BODIES      = 64;
    localparam int    HOLD_AT       = 500;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    SETTLE_CYCLES = 4;
    localparam longint CYCLE_LIMIT  = 200000;

    // Smoothing weights out of 256 and the rounding offset.
    localparam logic [31:0] OLD_WEIGHT  = 32'd205;
    localparam logic [31:0] NEW_WEIGHT  = 32'd51;
    localparam logic [31:0] ROUND_HALF  = 32'd128;

    // A register index that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]    body;
        logic [SPEED_W-1:0] lin_now;
        logic [SPEED_W-1:0] ang_now;
        logic               disturbed;
        logic               in_island;
    } rest_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    body;
        logic               cand;
        logic [SPEED_W-1:0] lin;
        logic [SPEED_W-1:0] ang;
        logic [DWELL_W-1:0] dwell;
    } rest_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    brd_in_if  in_ch ();
    brd_out_if out_ch ();

    body_rest_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Register copies used for prediction.
    logic [SPEED_W-1:0] lin_thr_q;
    logic [SPEED_W-1:0] ang_thr_q;
    logic [WAKE_W-1:0]  wake_q;
    logic [STEP_W-1:0]  step_q;
    logic [DWELL_W-1:0] delay_q;

    // Per-body rest state as the block should hold it.
    logic [SPEED_W-1:0] lin_mem   [N_BODIES];
    logic [SPEED_W-1:0] ang_mem   [N_BODIES];
    logic [DWELL_W-1:0] dwell_mem [N_BODIES];
    logic               cand_mem  [N_BODIES];

    rest_item_t   pending_items[$];
    rest_result_t expected_rest[$];
    rest_item_t   cur_item;
    rest_result_t want;

    int     send_idle_pct;
    int     recv_idle_pct;
    int     items_queued;
    int     results_seen;
    int     accepted_count;
    int     hold_left;
    bit     hold_done;
    int     errors;
    longint cycles;

    // Clock generation.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Fixed-point exponential average of one speed.
    function automatic logic [SPEED_W-1:0] blend_speed(input logic [SPEED_W-1:0] old_v,
                                                       input logic [SPEED_W-1:0] now_v);
        logic [31:0] acc;
        acc = OLD_WEIGHT * 32'(old_v) + NEW_WEIGHT * 32'(now_v) + ROUND_HALF;
        return acc[SPEED_W+7:8];
    endfunction

    // Update the stored rest state of one body and return the result it reports.
    function automatic rest_result_t predict_rest(input rest_item_t it);
        rest_result_t     r;
        logic [SPEED_W-1:0] lin;
        logic [SPEED_W-1:0] ang;
        logic [DWELL_W:0]   sum;
        logic               lin_wake;
        logic               ang_wake;
        logic               quiet;
        int                 b;
        b = it.body;
        if (!it.in_island)
        begin
            cand_mem[b] = 1'b0;
        end
        else
        begin
            lin = blend_speed(lin_mem[b], it.lin_now);
            ang = blend_speed(ang_mem[b], it.ang_now);
            lin_mem[b] = lin;
            ang_mem[b] = ang;
            if (cand_mem[b])
            begin
                // Hysteresis: compare against the scaled wake band exactly.
                lin_wake = {12'd0, lin, 4'd0} > 32'(wake_q) * 32'(lin_thr_q);
                ang_wake = {12'd0, ang, 4'd0} > 32'(wake_q) * 32'(ang_thr_q);
                if (it.disturbed || lin_wake || ang_wake)
                    cand_mem[b] = 1'b0;
            end
            else
            begin
                quiet = (lin < lin_thr_q) && (ang < ang_thr_q) && !it.disturbed;
                if (quiet)
                begin
                    sum = {1'b0, dwell_mem[b]} + (DWELL_W+1)'(step_q);
                    if (sum > {1'b0, DWELL_MAX})
                        sum = {1'b0, DWELL_MAX};
                    dwell_mem[b] = sum[DWELL_W-1:0];
                    if (dwell_mem[b] >= delay_q)
                        cand_mem[b] = 1'b1;
                end
                else
                begin
                    dwell_mem[b] = '0;
                end
            end
        end
        r.body  = it.body;
        r.cand  = cand_mem[b];
        r.lin   = lin_mem[b];
        r.ang   = ang_mem[b];
        r.dwell = dwell_mem[b];
        return r;
    endfunction

    // Random body record: mostly quiet samples on a few bodies, some loud ones and noise.
    function automatic rest_item_t make_item(input int span, input int quiet_max,
                                             input int dist_pct);
        rest_item_t it;
        int         kind;
        if ($urandom_range(99) < 85)
            it.body = ID_W'($urandom_range(span - 1));
        else
            it.body = ID_W'($urandom_range(N_BODIES - 1));
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            it.lin_now = SPEED_W'($urandom_range(quiet_max));
            it.ang_now = SPEED_W'($urandom_range(quiet_max));
        end
        else if (kind < 90)
        begin
            it.lin_now = SPEED_W'($urandom_range(65535));
            it.ang_now = SPEED_W'($urandom_range(65535));
        end
        else
        begin
            it.lin_now = SPEED_W'($urandom_range(quiet_max));
            it.ang_now = SPEED_W'($urandom_range(65535));
        end
        it.disturbed = ($urandom_range(99) < dist_pct);
        it.in_island = ($urandom_range(99) < 93);
        return it;
    endfunction

    task automatic queue_item(input rest_item_t it);
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    task automatic queue_body(input int body, input int lin, input int ang,
                              input bit dist_flag, input bit isl);
        rest_item_t it;
        it.body      = ID_W'(body);
        it.lin_now   = SPEED_W'(lin);
        it.ang_now   = SPEED_W'(ang);
        it.disturbed = dist_flag;
        it.in_island = isl;
        queue_item(it);
    endtask

    task automatic run_random(input int n, input int span, input int quiet_max,
                              input int dist_pct);
        repeat (n) queue_item(make_item(span, quiet_max, dist_pct));
    endtask

    // Wait until every queued item has produced its result, then let the pipe settle.
    task automatic drain();
        while (results_seen != items_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
    endtask

    // Program all five registers and mirror them in the predictor.
    task automatic set_regs(input int lin_thr, input int ang_thr, input int wake,
                            input int step, input int delay);
        write_reg(CFG_LIN_THR, lin_thr);
        write_reg(CFG_ANG_THR, ang_thr);
        write_reg(CFG_WAKE_SCALE, wake);
        write_reg(CFG_TIME_STEP, step);
        write_reg(CFG_SLEEP_DLY, delay);
        @(posedge clk);
        cfg_we    <= 1'b0;
        lin_thr_q = SPEED_W'(lin_thr);
        ang_thr_q = SPEED_W'(ang_thr);
        wake_q    = WAKE_W'(wake);
        step_q    = STEP_W'(step);
        delay_q   = DWELL_W'(delay);
    endtask

    // Driver: offer queued items and predict each one at its transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_rest = {expected_rest, predict_rest(cur_item)};
                accepted_count <= accepted_count + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    in_ch.body_index    <= cur_item.body;
                    in_ch.lin_speed_now <= cur_item.lin_now;
                    in_ch.ang_speed_now <= cur_item.ang_now;
                    in_ch.disturbed     <= cur_item.disturbed;
                    in_ch.in_island     <= cur_item.in_island;
                    in_ch.valid         <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer and drive ready with random stalls and one long stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_rest.size() == 0)
                begin
                    $error("result for body %0d with no transfer waiting", out_ch.body_id);
                    errors++;
                end
                else
                begin
                    want = expected_rest.pop_front();
                    if (out_ch.body_id !== want.body)
                    begin
                        $error("body_id: expected %0d, got %0d", want.body, out_ch.body_id);
                        errors++;
                    end
                    if (out_ch.sleep_candidate !== want.cand)
                    begin
                        $error("sleep_candidate: expected %0d, got %0d", want.cand,
                               out_ch.sleep_candidate);
                        errors++;
                    end
                    if (out_ch.lin_speed_smooth !== want.lin)
                    begin
                        $error("lin_speed_smooth: expected %0d, got %0d", want.lin,
                               out_ch.lin_speed_smooth);
                        errors++;
                    end
                    if (out_ch.ang_speed_smooth !== want.ang)
                    begin
                        $error("ang_speed_smooth: expected %0d, got %0d", want.ang,
                               out_ch.ang_speed_smooth);
                        errors++;
                    end
                    if (out_ch.dwell_us !== want.dwell)
                    begin
                        $error("dwell_us: expected %0d, got %0d", want.dwell, out_ch.dwell_us);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && accepted_count >= HOLD_AT)
            begin
                // One long hold-off so the block backs up and stalls its input.
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.body_index    = '0;
        in_ch.lin_speed_now = '0;
        in_ch.ang_speed_now = '0;
        in_ch.disturbed     = 1'b0;
        in_ch.in_island     = 1'b0;
        out_ch.ready        = 1'b0;
        lin_thr_q           = 16'd26;
        ang_thr_q           = 16'd26;
        wake_q              = 8'd32;
        step_q              = 16'd1000;
        delay_q             = 24'd500000;
        items_queued        = 0;
        results_seen        = 0;
        accepted_count      = 0;
        errors              = 0;
        cycles              = 0;
        send_idle_pct       = 8;
        recv_idle_pct       = 63;
        for (int k = 0; k < N_BODIES; k++)
        begin
            lin_mem[k]   = '0;
            ang_mem[k]   = '0;
            dwell_mem[k] = '0;
            cand_mem[k]  = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: two quiet steps make a candidate, then each way out of candidacy.
        set_regs(100, 100, 32, 65535, 131070);
        queue_body(5, 0, 0, 1'b0, 1'b1);
        queue_body(5, 0, 0, 1'b0, 1'b1);
        queue_body(5, 0, 0, 1'b1, 1'b1);
        queue_body(5, 10, 10, 1'b0, 1'b1);
        queue_body(5, 65535, 0, 1'b0, 1'b1);
        queue_body(5, 0, 0, 1'b0, 1'b0);
        queue_body(63, 65535, 65535, 1'b0, 1'b1);
        queue_body(63, 65535, 65535, 1'b0, 1'b1);
        queue_body(63, 65535, 65535, 1'b1, 1'b0);
        queue_body(0, 0, 65535, 1'b0, 1'b1);
        queue_body(0, 0, 0, 1'b1, 1'b0);
        queue_body(7, 1, 1, 1'b0, 1'b1);
        queue_body(7, 1, 1, 1'b0, 1'b1);
        queue_body(7, 0, 40000, 1'b0, 1'b1);
        queue_body(7, 0, 0, 1'b0, 1'b1);
        queue_body(9, 0, 0, 1'b0, 1'b1);
        queue_body(9, 0, 0, 1'b0, 1'b1);
        queue_body(9, 0, 0, 1'b0, 1'b0);
        queue_body(9, 0, 0, 1'b0, 1'b1);
        queue_body(42, 21845, 43690, 1'b1, 1'b1);
        drain();

        // Reset-value registers, all bodies.
        set_regs(26, 26, 32, 1000, 500000);
        run_random(250, 64, 25, 4);
        drain();

        // Short dwell on a few bodies so candidacy comes and goes often.
        set_regs(300, 300, 32, 20000, 100000);
        run_random(450, 8, 200, 4);
        drain();

        // Upper extremes: dwell saturates on one body in the same update that turns it candidate.
        send_idle_pct = 63;
        recv_idle_pct = 8;
        set_regs(65535, 65535, 255, 65535, 16777215);
        run_random(450, 1, 60000, 0);
        run_random(100, 2, 60000, 10);
        drain();

        // Zero sleep bands never count as quiet; spare index must be ignored.
        write_reg(CFG_SPARE_IDX, 24'hABCDEF);
        set_regs(0, 0, 16, 1, 0);
        run_random(200, 16, 0, 4);
        drain();

        // Zero wake scale drops a candidate at any nonzero speed; zero delay.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(1000, 2000, 0, 1, 0);
        run_random(300, 16, 1500, 5);
        drain();

        // Wake band equal to the sleep band, at a wake scale of 16.
        set_regs(500, 500, 16, 250, 1000);
        run_random(300, 8, 600, 4);
        drain();

        if (errors == 0 && expected_rest.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
